### design/tmde_pkg.sv
// ----------------------------------------------------------------------------
// tmde_pkg
// Shared types and constants for the TMDS byte encoder.
// ----------------------------------------------------------------------------
package tmde_pkg;

    localparam int DATA_W      = 8;
    localparam int SYMBOL_W    = 10;
    localparam int ONES_W      = 4;
    localparam int DISP_W      = 6;
    localparam int TMDS_HALF   = 4;
    localparam int XOR_BIT     = 8;
    localparam int INV_BIT     = 9;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one transition-minimized byte, classified for the balance stage
    typedef struct packed {
        logic [DATA_W-1:0] qm;
        logic              xor_mode;
        logic [ONES_W-1:0] ones;
    } qm_entry_t;

    function automatic logic [ONES_W-1:0] count_ones8(input logic [DATA_W-1:0] v);
        logic [ONES_W-1:0] n;
        n = '0;
        for (int i = 0; i < DATA_W; i++) begin
            n = n + ONES_W'(v[i]);
        end
        return n;
    endfunction

endpackage

### design/tmde_front.sv
// ----------------------------------------------------------------------------
// tmde_front
// Accepts data bytes, picks xor or xnor chain and registers the
// transition-minimized byte with its count of ones.
// ----------------------------------------------------------------------------
module tmde_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tmde_pkg::DATA_W-1:0] s_data_byte,
    output logic                       push_valid,
    input  logic                       push_ready,
    output tmde_pkg::qm_entry_t        push_entry
);
    import tmde_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    qm_entry_t         entry_reg;
    logic [ONES_W-1:0] n1d;
    logic              use_xnor;
    logic [DATA_W-1:0] qm;

    always_comb begin
        n1d      = count_ones8(s_data_byte);
        use_xnor = (n1d > ONES_W'(TMDS_HALF)) ||
                   ((n1d == ONES_W'(TMDS_HALF)) && !s_data_byte[0]);
        qm[0] = s_data_byte[0];
        for (int i = 1; i < DATA_W; i++) begin
            qm[i] = qm[i-1] ^ s_data_byte[i] ^ use_xnor;
        end
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            entry_reg.qm       <= qm;
            entry_reg.xor_mode <= !use_xnor;
            entry_reg.ones     <= count_ones8(qm);
        end
    end

endmodule

### design/tmde_queue.sv
// ----------------------------------------------------------------------------
// tmde_queue
// Short register queue between the front and back parts; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module tmde_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  tmde_pkg::qm_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tmde_pkg::qm_entry_t pop_entry
);
    import tmde_pkg::*;

    qm_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### design/tmde_back.sv
// ----------------------------------------------------------------------------
// tmde_back
// Running-disparity balance stage: decides inversion, forms the symbol in
// an output register and updates the disparity counter.
// ----------------------------------------------------------------------------
module tmde_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  tmde_pkg::qm_entry_t          pop_entry,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tmde_pkg::SYMBOL_W-1:0] m_symbol
);
    import tmde_pkg::*;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [SYMBOL_W-1:0] symbol_reg;
    logic [SYMBOL_W-1:0] symbol_next;
    logic [DISP_W-1:0]   disp_reg;
    logic [DISP_W-1:0]   disp_next;
    logic [DISP_W-1:0]   diff;
    logic [DISP_W-1:0]   xor_two;
    logic [DISP_W-1:0]   xnor_two;
    logic                cnt_zero;
    logic                cnt_pos;
    logic                balanced;
    logic                more_ones;
    logic                invert;
    logic                take;

    assign pop_ready = !m_valid_reg || m_ready;
    assign take      = pop_valid && pop_ready;
    assign m_valid   = m_valid_reg;
    assign m_symbol  = symbol_reg;

    always_comb begin
        // ones minus zeros of the chain bits, 2*ones - 8
        diff      = DISP_W'({pop_entry.ones, 1'b0}) - DISP_W'(2 * TMDS_HALF);
        xor_two   = pop_entry.xor_mode ? DISP_W'(2) : '0;
        xnor_two  = pop_entry.xor_mode ? '0 : DISP_W'(2);
        cnt_zero  = (disp_reg == '0);
        cnt_pos   = !disp_reg[DISP_W-1] && !cnt_zero;
        balanced  = (pop_entry.ones == ONES_W'(TMDS_HALF));
        more_ones = (pop_entry.ones > ONES_W'(TMDS_HALF));

        if (cnt_zero || balanced) begin
            invert    = !pop_entry.xor_mode;
            disp_next = pop_entry.xor_mode ? disp_reg + diff : disp_reg - diff;
        end else if ((cnt_pos && more_ones) || (!cnt_pos && !more_ones)) begin
            invert    = 1'b1;
            disp_next = disp_reg + xor_two - diff;
        end else begin
            invert    = 1'b0;
            disp_next = disp_reg - xnor_two + diff;
        end

        symbol_next                = '0;
        symbol_next[DATA_W-1:0]    = invert ? ~pop_entry.qm : pop_entry.qm;
        symbol_next[XOR_BIT]       = pop_entry.xor_mode;
        symbol_next[INV_BIT]       = invert;

        m_valid_next = m_valid_reg;
        if (pop_ready) begin
            m_valid_next = pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            disp_reg    <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                disp_reg <= disp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            symbol_reg <= symbol_next;
        end
    end

endmodule

### design/tmds_byte_encoder.sv
// ----------------------------------------------------------------------------
// tmds_byte_encoder
// DVI TMDS data-period encoder: one byte in, one ten-bit symbol out.
// ----------------------------------------------------------------------------
// Takes one data byte per clock unless the output stalls, a sustained rate
// set by the running-disparity update in the back stage, which closes on
// itself each cycle, and returns one ten-bit TMDS symbol per transaction,
// in order: bits 0-7 the transition-minimized (and possibly inverted) byte,
// bit 8 set for xor mode, bit 9 set when bits 0-7 were inverted. Each byte
// passes through the front register, the queue and the back output register.
// A two-entry queue between the chain stage and the disparity stage lets
// the input keep flowing for a while when the output stalls.
module tmds_byte_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tmde_pkg::DATA_W-1:0]   s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tmde_pkg::SYMBOL_W-1:0] m_symbol
);
    import tmde_pkg::*;

    logic      push_valid;
    logic      push_ready;
    qm_entry_t push_entry;
    logic      pop_valid;
    logic      pop_ready;
    qm_entry_t pop_entry;

    tmde_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    tmde_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    tmde_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol)
    );

endmodule
